// File: src/fnc_pkg.sv
// shared types, constants and helper functions for the flock neighbor classifier
`default_nettype none

package fnc_pkg;

  // world geometry and fixed radii, Q12.4 world units
  localparam int WORLD_WIDTH  = 65536;
  localparam int WORLD_HEIGHT = 65536;
  localparam int CATCH_RADIUS = 160;
  localparam int FEED_RADIUS  = 320;

  // cordic depth and arctangent table size
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 20;

  // port and datapath widths
  localparam int IN_W   = 96;
  localparam int IN_UW  = 3;
  localparam int OUT_W  = 24;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;
  localparam int CW     = 19;
  localparam int D2W    = 33;

  // view cone reset value, two thirds of a turn
  localparam logic [16:0] CONE_RESET = 17'd43691;

  // squared fixed radii
  localparam logic [31:0] CATCH_SQ =
    32'(longint'(CATCH_RADIUS) * longint'(CATCH_RADIUS));
  localparam logic [31:0] FEED_SQ =
    32'(longint'(FEED_RADIUS) * longint'(FEED_RADIUS));

  // quarter turn offsets for the pre-rotation, 2^-32 turn units
  localparam logic [31:0] Z_QUARTER       = 32'h4000_0000;
  localparam logic [31:0] Z_THREE_QUARTER = 32'hC000_0000;

  // candidate kinds
  typedef enum logic [1:0] {
    KIND_MEMBER   = 2'd0,
    KIND_PREDATOR = 2'd1,
    KIND_FOOD     = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_DISTANCING = 3'd0,
    REG_ALIGNMENT  = 3'd1,
    REG_COHESION   = 3'd2,
    REG_PREDATION  = 3'd3,
    REG_FLED       = 3'd4,
    REG_BREED      = 3'd5,
    REG_FOV        = 3'd6,
    REG_INSTINCT   = 3'd7
  } reg_idx_t;

  // one item in the offset and cordic stages
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic [D2W-1:0]       d2;
    logic [31:0]          sqy;
    logic [15:0]          heading;
    logic [15:0]          tag;
    logic [1:0]           kind;
    logic                 is_self;
    logic                 zero;
  } item_t;

  // one item after the distance compares and the bearing difference
  typedef struct packed {
    logic        lt_dist;
    logic        lt_align;
    logic        lt_coh;
    logic        lt_pred;
    logic        lt_fled;
    logic        lt_breed;
    logic        lt_catch;
    logic        lt_feed;
    logic        gt_coh;
    logic        gt_breed;
    logic [15:0] diff;
    logic [15:0] tag;
    logic [1:0]  kind;
    logic        is_self;
  } fin_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    begin
      case (i)
        0:       r = 32'd536870912;
        1:       r = 32'd316933406;
        2:       r = 32'd167458907;
        3:       r = 32'd85004756;
        4:       r = 32'd42667331;
        5:       r = 32'd21354465;
        6:       r = 32'd10679838;
        7:       r = 32'd5340245;
        8:       r = 32'd2670163;
        9:       r = 32'd1335087;
        10:      r = 32'd667544;
        11:      r = 32'd333772;
        12:      r = 32'd166886;
        13:      r = 32'd83443;
        14:      r = 32'd41722;
        15:      r = 32'd20861;
        16:      r = 32'd10430;
        17:      r = 32'd5215;
        18:      r = 32'd2608;
        19:      r = 32'd1304;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // offset along one axis, wrapped once by the world size
  function automatic logic signed [16:0] wrap_axis(input logic [15:0] o,
                                                   input logic [15:0] s,
                                                   input int size);
    logic signed [16:0] d;
    logic [16:0]        mag;
    logic signed [18:0] dw;
    begin
      d   = $signed({1'b0, o}) - $signed({1'b0, s});
      mag = d[16] ? 17'(-d) : 17'(d);
      dw  = {{2{d[16]}}, d};
      if ({1'b0, mag, 1'b0} > 19'(size)) begin
        dw = d[16] ? dw + 19'(size) : dw - 19'(size);
      end
      return dw[16:0];
    end
  endfunction

  // entry stage: unpack the transfer and form the wrapped offset
  function automatic item_t entry_item(input logic [IN_W-1:0] d,
                                       input logic [IN_UW-1:0] u);
    item_t              it;
    logic signed [16:0] wx;
    logic signed [16:0] wy;
    begin
      it         = '0;
      wx         = wrap_axis(d[63:48], d[15:0], WORLD_WIDTH);
      wy         = wrap_axis(d[79:64], d[31:16], WORLD_HEIGHT);
      it.x       = {{(CW-17){wx[16]}}, wx};
      it.y       = {{(CW-17){wy[16]}}, wy};
      it.heading = d[47:32];
      it.tag     = d[95:80];
      it.kind    = u[1:0];
      it.is_self = u[2];
      return it;
    end
  endfunction

  // second stage: axis squares and quarter-turn pre-rotation
  function automatic item_t prep_item(input item_t p);
    item_t       it;
    logic [15:0] ax;
    logic [15:0] ay;
    begin
      it      = p;
      ax      = p.x[CW-1] ? 16'(-p.x) : p.x[15:0];
      ay      = p.y[CW-1] ? 16'(-p.y) : p.y[15:0];
      it.d2   = D2W'(ax * ax);
      it.sqy  = ay * ay;
      it.zero = (p.x == '0) && (p.y == '0);
      it.z    = '0;
      if (p.x[CW-1]) begin
        if (!p.y[CW-1]) begin
          it.x = p.y;
          it.y = -p.x;
          it.z = Z_QUARTER;
        end else begin
          it.x = -p.y;
          it.y = p.x;
          it.z = Z_THREE_QUARTER;
        end
      end
      return it;
    end
  endfunction

  // one cordic vectoring step; the first step also finishes the squared distance
  function automatic item_t cordic_step(input item_t p, input int k);
    item_t                it;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    begin
      it = p;
      xs = p.x >>> k;
      ys = p.y >>> k;
      if (k == 0) begin
        it.d2 = p.d2 + D2W'(p.sqy);
      end
      if (!p.y[CW-1]) begin
        it.x = p.x + ys;
        it.y = p.y - xs;
        it.z = p.z + atan_turn(k);
      end else begin
        it.x = p.x - ys;
        it.y = p.y + xs;
        it.z = p.z - atan_turn(k);
      end
      return it;
    end
  endfunction

  // true when twice the wrapped angle difference stays within the cone
  function automatic logic in_cone(input logic [15:0] diff, input logic [16:0] cone);
    logic [16:0] mag;
    begin
      mag = diff[15] ? 17'h10000 - {1'b0, diff} : {1'b0, diff};
      return {mag, 1'b0} <= {1'b0, cone};
    end
  endfunction

endpackage

`default_nettype wire

// File: src/flock_neighbor_classifier.sv
// flock neighbor classifier: toroidal offset, squared distance, cordic bearing, cone tests
//
// Usage: one candidate per transfer on the s_ stream, one result per candidate on the
// m_ stream, in order. s_tdata carries both positions, the heading and the tag; s_tuser
// carries the candidate kind and the self flag. m_tdata returns the tag and eight
// membership flags. Radii and cone angles are written on the cfg_ port while the
// block is idle; the radius squares are registered in the cycle after a write.
// The path from input transfer to result valid runs through an entry
// stage for the wrapped offset, a square and pre-rotation stage, one stage per cordic
// iteration, a compare stage and the output register. Throughput is one candidate per
// cycle while the receiver accepts; the cordic pipeline sets the depth, not the rate.
// Each stage holds a valid bit and loads whenever its successor is empty or moving, so
// bubbles close up and a new candidate is taken while a finished result waits. When
// the receiver stalls, the pipeline fills and s_tready drops only once every stage
// holds an item. Synchronous reset empties the pipeline and restores the registers:
// radii to zero, both cone angles to two thirds of a turn.
`default_nettype none

module flock_neighbor_classifier #(
  parameter int CORDIC_STAGES = fnc_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration write port
  input  wire logic                       cfg_we,
  input  wire logic [fnc_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [fnc_pkg::CFG_DW-1:0] cfg_wdata,
  // candidate stream
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // self_x, self_y, self_heading, other_x, other_y, candidate_tag
  input  wire logic [fnc_pkg::IN_W-1:0]   s_tdata,
  // other_kind, is_self
  input  wire logic [fnc_pkg::IN_UW-1:0]  s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // result_tag, in_distancing, in_alignment, in_cohesion, in_fled, in_predation,
  // in_catch, in_feed, in_breed
  output logic [fnc_pkg::OUT_W-1:0]       m_tdata
);

  import fnc_pkg::*;

  // entry, prep and one stage per cordic step; the compare stage follows these
  localparam int NST = CORDIC_STAGES + 2;

  // configuration registers
  logic [15:0] rad_dist;
  logic [15:0] rad_align;
  logic [15:0] rad_coh;
  logic [15:0] rad_pred;
  logic [15:0] rad_fled;
  logic [15:0] rad_breed;
  logic [16:0] fov;
  logic [16:0] instinct;

  // squared radii
  logic [31:0] sq_dist;
  logic [31:0] sq_align;
  logic [31:0] sq_coh;
  logic [31:0] sq_pred;
  logic [31:0] sq_fled;
  logic [31:0] sq_breed;

  // pipeline storage and flow control
  item_t         stg [NST];
  item_t         nx  [NST];
  fin_t          fin;
  fin_t          fin_next;
  logic [NST:0]  vld;
  logic [NST+1:0] rdy;
  logic [7:0]    flags;
  logic          gate;
  logic          cone_fov;
  logic          cone_inst;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rad_dist  <= '0;
      rad_align <= '0;
      rad_coh   <= '0;
      rad_pred  <= '0;
      rad_fled  <= '0;
      rad_breed <= '0;
      fov       <= CONE_RESET;
      instinct  <= CONE_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_DISTANCING: rad_dist  <= cfg_wdata[15:0];
        REG_ALIGNMENT:  rad_align <= cfg_wdata[15:0];
        REG_COHESION:   rad_coh   <= cfg_wdata[15:0];
        REG_PREDATION:  rad_pred  <= cfg_wdata[15:0];
        REG_FLED:       rad_fled  <= cfg_wdata[15:0];
        REG_BREED:      rad_breed <= cfg_wdata[15:0];
        REG_FOV:        fov       <= cfg_wdata;
        REG_INSTINCT:   instinct  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // radius squares follow the registers in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_dist  <= '0;
      sq_align <= '0;
      sq_coh   <= '0;
      sq_pred  <= '0;
      sq_fled  <= '0;
      sq_breed <= '0;
    end else begin
      sq_dist  <= rad_dist * rad_dist;
      sq_align <= rad_align * rad_align;
      sq_coh   <= rad_coh * rad_coh;
      sq_pred  <= rad_pred * rad_pred;
      sq_fled  <= rad_fled * rad_fled;
      sq_breed <= rad_breed * rad_breed;
    end
  end

  // ready chain: a stage loads when it is empty or its successor loads
  assign rdy[NST+1] = !m_tvalid || m_tready;
  for (genvar i = 0; i <= NST; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end
  assign s_tready = rdy[0];

  // stage functions: wrapped offset, squares and pre-rotation, cordic steps
  assign nx[0] = entry_item(s_tdata, s_tuser);
  assign nx[1] = prep_item(stg[0]);
  for (genvar i = 2; i < NST; i++) begin : g_cordic
    assign nx[i] = cordic_step(stg[i-1], i - 2);
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i <= NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) begin
        stg[i] <= nx[i];
      end
    end
  end

  // distance compares and bearing difference
  always_comb begin
    logic [31:0] bsum;
    logic [15:0] bear;
    item_t       p;
    p                 = stg[NST-1];
    bsum              = p.z + 32'h0000_8000;
    bear              = p.zero ? 16'd0 : bsum[31:16];
    fin_next.lt_dist  = p.d2 < D2W'(sq_dist);
    fin_next.lt_align = p.d2 < D2W'(sq_align);
    fin_next.lt_coh   = p.d2 < D2W'(sq_coh);
    fin_next.lt_pred  = p.d2 < D2W'(sq_pred);
    fin_next.lt_fled  = p.d2 < D2W'(sq_fled);
    fin_next.lt_breed = p.d2 < D2W'(sq_breed);
    fin_next.lt_catch = p.d2 < D2W'(CATCH_SQ);
    fin_next.lt_feed  = p.d2 < D2W'(FEED_SQ);
    fin_next.gt_coh   = p.d2 > D2W'(sq_coh);
    fin_next.gt_breed = p.d2 > D2W'(sq_breed);
    fin_next.diff     = bear - p.heading;
    fin_next.tag      = p.tag;
    fin_next.kind     = p.kind;
    fin_next.is_self  = p.is_self;
  end

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      fin <= fin_next;
    end
  end

  // cone tests and flag selection by kind
  always_comb begin
    cone_fov  = in_cone(fin.diff, fov);
    cone_inst = in_cone(fin.diff, instinct);
    gate      = !(fin.gt_coh && fin.gt_breed) && (fin.kind != KIND_UNKNOWN) &&
                !(fin.is_self && (fin.kind != KIND_FOOD));
    flags     = '0;
    if (gate) begin
      case (kind_t'(fin.kind))
        KIND_MEMBER: begin
          flags[7] = fin.lt_breed;
          flags[0] = cone_fov && fin.lt_dist;
          flags[1] = cone_fov && fin.lt_align;
          flags[2] = cone_fov && fin.lt_coh;
          flags[4] = cone_fov && fin.lt_pred;
        end
        KIND_PREDATOR: begin
          flags[5] = fin.lt_catch;
          flags[3] = cone_inst && fin.lt_fled;
        end
        KIND_FOOD: begin
          flags[6] = cone_fov && fin.lt_feed;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy[NST+1]) begin
      m_tvalid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST+1]) begin
      m_tdata <= {flags, fin.tag};
    end
  end

  // an input transfer always lands in the entry stage
  a_entry_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted candidate missing from entry stage");

  // input back-pressure only when the whole pipeline is full behind a stalled output
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready && (&vld))
    else $error("input stalled while the pipeline has room");

  // flags of different kinds never appear together
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones({|{m_tdata[16], m_tdata[17], m_tdata[18], m_tdata[20],
                               m_tdata[23]},
                             |{m_tdata[19], m_tdata[21]},
                             m_tdata[22]}) <= 1)
    else $error("result carries flags of more than one kind");

endmodule

`default_nettype wire
